/* hw/rtl/qvra_pkg.sv */
// types and constants shared by the quaternion vector rotate-add core
package qvra_pkg;

    localparam int FIX_W  = 32;   // Q16.16 vector components
    localparam int QUAT_W = 16;   // Q2.14 quaternion components
    localparam int PROD_W = 32;   // product of two quaternion components
    localparam int MAT_W  = 34;   // rotation matrix coefficient, 2^-28 per unit
    localparam int HALF_W = 16;   // split of a vector component into high and low halves
    localparam int PHI_W  = MAT_W + HALF_W;       // coefficient times signed high half
    localparam int PLO_W  = MAT_W + HALF_W + 1;   // coefficient times unsigned low half
    localparam int SUM_W  = 52;   // sum of three partial products
    localparam int ACC_W  = 68;   // full row sum, 2^-44 per unit
    localparam int RND_SHIFT = 28;                // 2^-44 down to Q16.16
    localparam int RND_W  = ACC_W - RND_SHIFT;    // rounded rotation
    localparam int EXT_W  = RND_W + 1;            // rounded rotation plus offset
    localparam int LATENCY = 7;   // depth from start to done

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'sd134217728);
    localparam logic signed [EXT_W-1:0] SAT_MAX  = EXT_W'(64'sd2147483647);
    localparam logic signed [EXT_W-1:0] SAT_MIN  = EXT_W'(-64'sd2147483648);
    localparam logic signed [FIX_W-1:0] FIX_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [FIX_W-1:0] FIX_MIN  = 32'sh8000_0000;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 8'd3;

    localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;

    typedef logic signed [FIX_W-1:0]  fix_t;
    typedef logic signed [QUAT_W-1:0] quat_elem_t;
    typedef logic signed [MAT_W-1:0]  mat_elem_t;
    typedef mat_elem_t [2:0] mat_row_t;
    typedef mat_row_t  [2:0] mat_t;
    typedef fix_t      [2:0] vec_t;

    typedef struct packed {
        quat_elem_t x;
        quat_elem_t y;
        quat_elem_t z;
        quat_elem_t w;
    } quat_t;

    typedef struct packed {
        fix_t in_x;
        fix_t in_y;
        fix_t in_z;
        fix_t offset_x;
        fix_t offset_y;
        fix_t offset_z;
    } qvra_in_t;

    typedef struct packed {
        fix_t out_x;
        fix_t out_y;
        fix_t out_z;
        logic overflow;
    } qvra_out_t;

endpackage

/* hw/rtl/qvra_matrix.sv */
// rotation matrix from the configured quaternion, two register stages
module qvra_matrix
    import qvra_pkg::*;
(
    input  logic  clk,
    input  quat_t quat,
    output mat_t  mat
);

    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    mat_t mat_reg;
    mat_t mat_next;

    // component products, recomputed every cycle
    always_ff @(posedge clk)
    begin
        ww_reg <= PROD_W'(quat.w) * PROD_W'(quat.w);
        xx_reg <= PROD_W'(quat.x) * PROD_W'(quat.x);
        yy_reg <= PROD_W'(quat.y) * PROD_W'(quat.y);
        zz_reg <= PROD_W'(quat.z) * PROD_W'(quat.z);
        xy_reg <= PROD_W'(quat.x) * PROD_W'(quat.y);
        xz_reg <= PROD_W'(quat.x) * PROD_W'(quat.z);
        yz_reg <= PROD_W'(quat.y) * PROD_W'(quat.z);
        wx_reg <= PROD_W'(quat.w) * PROD_W'(quat.x);
        wy_reg <= PROD_W'(quat.w) * PROD_W'(quat.y);
        wz_reg <= PROD_W'(quat.w) * PROD_W'(quat.z);
    end

    always_comb
    begin
        mat_next[0][0] = MAT_W'(ww_reg) + MAT_W'(xx_reg) - MAT_W'(yy_reg) - MAT_W'(zz_reg);
        mat_next[0][1] = (MAT_W'(xy_reg) - MAT_W'(wz_reg)) <<< 1;
        mat_next[0][2] = (MAT_W'(xz_reg) + MAT_W'(wy_reg)) <<< 1;
        mat_next[1][0] = (MAT_W'(xy_reg) + MAT_W'(wz_reg)) <<< 1;
        mat_next[1][1] = MAT_W'(ww_reg) - MAT_W'(xx_reg) + MAT_W'(yy_reg) - MAT_W'(zz_reg);
        mat_next[1][2] = (MAT_W'(yz_reg) - MAT_W'(wx_reg)) <<< 1;
        mat_next[2][0] = (MAT_W'(xz_reg) - MAT_W'(wy_reg)) <<< 1;
        mat_next[2][1] = (MAT_W'(yz_reg) + MAT_W'(wx_reg)) <<< 1;
        mat_next[2][2] = MAT_W'(ww_reg) - MAT_W'(xx_reg) - MAT_W'(yy_reg) + MAT_W'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        mat_reg <= mat_next;
    end

    assign mat = mat_reg;

endmodule

/* hw/rtl/qvra_row.sv */
// one output component: dot product, rounding, offset add and saturation
module qvra_row
    import qvra_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     valid,
    input  mat_row_t coef,
    input  vec_t     vec,
    input  fix_t     offset,
    output logic     valid_out,
    output fix_t     value,
    output logic     ovf
);

    // stage a: partial products
    logic [3:0] valid_reg;
    logic signed [PHI_W-1:0] phi_reg  [3];
    logic signed [PLO_W-1:0] plo_reg  [3];
    logic signed [PHI_W-1:0] phi_next [3];
    logic signed [PLO_W-1:0] plo_next [3];
    fix_t off_a_reg, off_b_reg, off_c_reg;
    // stage b: sums
    logic signed [SUM_W-1:0] sum_hi_reg, sum_lo_reg;
    logic signed [SUM_W-1:0] sum_hi_next, sum_lo_next;
    // stage c: rounding
    logic signed [ACC_W-1:0] acc;
    logic signed [RND_W-1:0] rnd_reg, rnd_next;
    // stage d: offset and clamp
    logic signed [EXT_W-1:0] total;
    fix_t value_reg, value_next;
    logic ovf_reg, ovf_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            phi_next[k] = PHI_W'(coef[k]) * PHI_W'($signed(vec[k][FIX_W-1:HALF_W]));
            plo_next[k] = PLO_W'(coef[k]) * PLO_W'($signed({1'b0, vec[k][HALF_W-1:0]}));
        end
        sum_hi_next = SUM_W'(phi_reg[0]) + SUM_W'(phi_reg[1]) + SUM_W'(phi_reg[2]);
        sum_lo_next = SUM_W'(plo_reg[0]) + SUM_W'(plo_reg[1]) + SUM_W'(plo_reg[2]);
        // round half up to Q16.16
        acc = (ACC_W'(sum_hi_reg) <<< HALF_W) + ACC_W'(sum_lo_reg) + ACC_HALF;
        rnd_next = acc[ACC_W-1:RND_SHIFT];
        total = EXT_W'(rnd_reg) + EXT_W'(off_c_reg);
        if (total > SAT_MAX)
        begin
            value_next = FIX_MAX;
            ovf_next   = 1'b1;
        end
        else if (total < SAT_MIN)
        begin
            value_next = FIX_MIN;
            ovf_next   = 1'b1;
        end
        else
        begin
            value_next = total[FIX_W-1:0];
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], valid};
        end
    end

    always_ff @(posedge clk)
    begin
        phi_reg    <= phi_next;
        plo_reg    <= plo_next;
        off_a_reg  <= offset;
        sum_hi_reg <= sum_hi_next;
        sum_lo_reg <= sum_lo_next;
        off_b_reg  <= off_a_reg;
        rnd_reg    <= rnd_next;
        off_c_reg  <= off_b_reg;
        value_reg  <= value_next;
        ovf_reg    <= ovf_next;
    end

    assign valid_out = valid_reg[3];
    assign value     = value_reg;
    assign ovf       = ovf_reg;

endmodule

/* hw/rtl/quaternion_vector_rotate_add_core.sv */
// top level of the quaternion vector rotate-add core
//
// rotates a Q16.16 vector by the configured Q2.14 quaternion and adds an offset,
// result = q*v*conj(q) + offset, with no normalization of q (a non-unit q scales
// the result by |q|^2). a transfer is taken on every clock edge with start high;
// busy is always low, so one vector can enter per cycle with no gaps. each result
// appears on result for exactly one cycle with done high; its depth from start
// comes from the partial-product multipliers, the row sum, the wide rounding add
// and the saturating offset add, each one register stage, behind three stages that
// line the vector up with the rotation matrix.
// the rotation is rounded to nearest Q16.16 (ties up) before the offset is added;
// each component then clamps to the 32-bit range and overflow flags any clamp.
// the quaternion registers (index 0..3 = x, y, z, w; other indexes ignored) are
// written through the cfg port, always ready, and may change only while no
// vector is in flight; reset gives the identity quaternion
module quaternion_vector_rotate_add_core
    import qvra_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  qvra_in_t             item,
    output logic                 done,
    output qvra_out_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [QUAT_W-1:0]    cfg_data
);

    quat_t    quat_reg;
    mat_t     mat;
    // vector waits three stages while the matrix follows the registers
    logic [2:0] stage_valid_reg;
    qvra_in_t   stage_item_reg [3];
    vec_t       vec;
    vec_t       offs;
    logic [2:0] row_valid;
    fix_t       row_value [3];
    logic [2:0] row_ovf;

    assign busy      = 1'b0;   // never stalls
    assign cfg_ready = 1'b1;

    // quaternion registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.x <= '0;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
            quat_reg.w <= QUAT_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_QUAT_X: quat_reg.x <= cfg_data;
                REG_QUAT_Y: quat_reg.y <= cfg_data;
                REG_QUAT_Z: quat_reg.z <= cfg_data;
                REG_QUAT_W: quat_reg.w <= cfg_data;
                default:    ;   // unmapped index, write dropped
            endcase
        end
    end

    // matrix products and sums, free running from the registers
    qvra_matrix u_matrix (
        .clk  (clk),
        .quat (quat_reg),
        .mat  (mat)
    );

    // input transfer and alignment stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= {stage_valid_reg[1:0], start && !busy};
        end
    end

    always_ff @(posedge clk)
    begin
        stage_item_reg[0] <= item;
        stage_item_reg[1] <= stage_item_reg[0];
        stage_item_reg[2] <= stage_item_reg[1];
    end

    assign vec[0]  = stage_item_reg[2].in_x;
    assign vec[1]  = stage_item_reg[2].in_y;
    assign vec[2]  = stage_item_reg[2].in_z;
    assign offs[0] = stage_item_reg[2].offset_x;
    assign offs[1] = stage_item_reg[2].offset_y;
    assign offs[2] = stage_item_reg[2].offset_z;

    // one row unit per output component
    for (genvar i = 0; i < 3; i++)
    begin : g_row
        qvra_row u_row (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid     (stage_valid_reg[2]),
            .coef      (mat[i]),
            .vec       (vec),
            .offset    (offs[i]),
            .valid_out (row_valid[i]),
            .value     (row_value[i]),
            .ovf       (row_ovf[i])
        );
    end

    assign done            = row_valid[0];
    assign result.out_x    = row_value[0];
    assign result.out_y    = row_value[1];
    assign result.out_z    = row_value[2];
    assign result.overflow = |row_ovf;

    // every result traces back to a start transfer at the fixed depth
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("done without a matching start");

    // identity quaternion with zero offset passes the vector through unchanged
    a_identity_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (done && quat_reg.x == '0 && quat_reg.y == '0 && quat_reg.z == '0
            && quat_reg.w == QUAT_ONE
            && $past(item.offset_x, LATENCY) == '0
            && $past(item.offset_y, LATENCY) == '0
            && $past(item.offset_z, LATENCY) == '0)
        |-> (result.out_x == $past(item.in_x, LATENCY)
            && result.out_y == $past(item.in_y, LATENCY)
            && result.out_z == $past(item.in_z, LATENCY)
            && !result.overflow))
        else $error("identity rotation altered the vector");

    // a flagged overflow leaves at least one component on a rail
    a_ovf_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |->
            (result.out_x == FIX_MAX || result.out_x == FIX_MIN
            || result.out_y == FIX_MAX || result.out_y == FIX_MIN
            || result.out_z == FIX_MAX || result.out_z == FIX_MIN))
        else $error("overflow flagged with no clamped component");

    // the three row units stay in step
    a_rows_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid[0] == row_valid[1] && row_valid[1] == row_valid[2])
        else $error("row units out of step");

endmodule

/* dv/testbench.sv */
// testbench for the quaternion vector rotate-add core: directed table, then random phases
`timescale 1ns / 1ps

module testbench;
    import qvra_pkg::*;

    // wide signed type for exact matrix arithmetic, far beyond any intermediate here
    typedef logic signed [127:0] wide_t;

    localparam fix_t        ONE      = 32'sh0001_0000;    // 1.0 in Q16.16
    localparam quat_elem_t  QMIN     = 16'sh8000;
    localparam quat_elem_t  QMAX     = 16'sh7FFF;
    localparam wide_t       ROUND_HALF = 128'sd134217728; // half a Q16.16 step at 2^-44
    localparam wide_t       SAT_HI   = 128'sd2147483647;
    localparam wide_t       SAT_LO   = -128'sd2147483648;
    localparam int          WATCHDOG_LIMIT = 2000;

    // one row of the directed table; want is only meaningful when typed is set
    typedef struct {
        bit        load_quat;
        quat_t     quat;
        bit        stray_write;
        qvra_in_t  vec;
        bit        typed;
        qvra_out_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 start = 1'b0;
    logic                 busy;
    qvra_in_t             item = '0;
    logic                 done;
    qvra_out_t            result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [QUAT_W-1:0]    cfg_data = '0;

    // quaternion as the block should hold it after the writes so far
    quat_t       quat_model = '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: QUAT_ONE};
    qvra_out_t   expected_q [$];
    stim_row_t   directed_rows [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;

    quaternion_vector_rotate_add_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // exact q*v*conj(q) + offset: matrix form, one rounding to q16.16 (ties up), then clamp
    function automatic qvra_out_t rotate_add(quat_t q, qvra_in_t v);
        wide_t     qx, qy, qz, qw;
        wide_t     m [3][3];
        wide_t     vin [3];
        wide_t     off [3];
        wide_t     acc, rot;
        fix_t      comp [3];
        logic      ovf;
        qvra_out_t res;
        qx = q.x;
        qy = q.y;
        qz = q.z;
        qw = q.w;
        vin[0] = v.in_x;
        vin[1] = v.in_y;
        vin[2] = v.in_z;
        off[0] = v.offset_x;
        off[1] = v.offset_y;
        off[2] = v.offset_z;
        m[0][0] = qw*qw + qx*qx - qy*qy - qz*qz;
        m[0][1] = 2 * (qx*qy - qw*qz);
        m[0][2] = 2 * (qx*qz + qw*qy);
        m[1][0] = 2 * (qx*qy + qw*qz);
        m[1][1] = qw*qw - qx*qx + qy*qy - qz*qz;
        m[1][2] = 2 * (qy*qz - qw*qx);
        m[2][0] = 2 * (qx*qz - qw*qy);
        m[2][1] = 2 * (qy*qz + qw*qx);
        m[2][2] = qw*qw - qx*qx - qy*qy + qz*qz;
        ovf = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = m[i][0]*vin[0] + m[i][1]*vin[1] + m[i][2]*vin[2];
            // arithmetic shift is a floor, so adding half first rounds ties upward
            rot = ((acc + ROUND_HALF) >>> 28) + off[i];
            if (rot > SAT_HI)
            begin
                rot = SAT_HI;
                ovf = 1'b1;
            end
            else if (rot < SAT_LO)
            begin
                rot = SAT_LO;
                ovf = 1'b1;
            end
            comp[i] = rot[31:0];
        end
        res.out_x = comp[0];
        res.out_y = comp[1];
        res.out_z = comp[2];
        res.overflow = ovf;
        return res;
    endfunction

    function automatic quat_t mk_quat(quat_elem_t x, quat_elem_t y, quat_elem_t z,
                                      quat_elem_t w);
        quat_t q;
        q.x = x;
        q.y = y;
        q.z = z;
        q.w = w;
        return q;
    endfunction

    function automatic qvra_in_t mk_in(fix_t ix, fix_t iy, fix_t iz,
                                       fix_t ox, fix_t oy, fix_t oz);
        qvra_in_t v;
        v.in_x = ix;
        v.in_y = iy;
        v.in_z = iz;
        v.offset_x = ox;
        v.offset_y = oy;
        v.offset_z = oz;
        return v;
    endfunction

    function automatic qvra_out_t mk_out(fix_t x, fix_t y, fix_t z, logic ovf);
        qvra_out_t r;
        r.out_x = x;
        r.out_y = y;
        r.out_z = z;
        r.overflow = ovf;
        return r;
    endfunction

    task automatic add_row(bit load_quat, quat_t q, bit stray, qvra_in_t v, bit typed,
                           qvra_out_t want);
        stim_row_t r;
        r.load_quat = load_quat;
        r.quat = q;
        r.stray_write = stray;
        r.vec = v;
        r.typed = typed;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    // extremes, tiny values, mid-range and full random words
    function automatic fix_t rand_fix();
        case ($urandom_range(9))
            0: return FIX_MAX;
            1: return FIX_MIN;
            2: return fix_t'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
            3, 4: return fix_t'($urandom) >>> 8;
            default: return fix_t'($urandom);
        endcase
    endfunction

    function automatic fix_t rand_offset();
        if ($urandom_range(3) == 0)
            return '0;
        return rand_fix();
    endfunction

    function automatic quat_elem_t rand_quat_elem();
        case ($urandom_range(7))
            0: return QMIN;
            1: return QMAX;
            2: return 16'sd0;
            3: return QUAT_ONE;
            4: return -QUAT_ONE;
            default: return quat_elem_t'($urandom);
        endcase
    endfunction

    task automatic flag_error(string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // sampled at negedge so the monitor's pop at the same posedge is already done
    task automatic wait_for_results();
        @(negedge clk);
        while (expected_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // one register transfer; valid stays high so back-to-back writes need no bubble
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [QUAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_QUAT_X: quat_model.x = data;
            REG_QUAT_Y: quat_model.y = data;
            REG_QUAT_Z: quat_model.z = data;
            REG_QUAT_W: quat_model.w = data;
            default: ;   // out-of-range index is dropped by the block
        endcase
    endtask

    // quaternion changes only with the pipeline empty
    task automatic set_quat(quat_t q, bit stray);
        start <= 1'b0;
        wait_for_results();
        write_reg(REG_QUAT_X, q.x);
        write_reg(REG_QUAT_Y, q.y);
        write_reg(REG_QUAT_Z, q.z);
        write_reg(REG_QUAT_W, q.w);
        if (stray)
            write_reg(CFG_IDX_W'($urandom_range(255, 4)), QUAT_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // random idle cycles, then one start transfer; the expectation is queued on acceptance
    task automatic send_vector(qvra_in_t v, int idle_pct, bit typed, qvra_out_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= v;
        do
            @(posedge clk);
        while (busy);
        expected_q.push_back(typed ? want : rotate_add(quat_model, v));
    endtask

    // result checker and watchdog; results can't be held off, so every done is a transfer
    always @(posedge clk)
    begin
        qvra_out_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
                flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
            else
            begin
                want = expected_q.pop_front();
                if (result.out_x !== want.out_x)
                    flag_error($sformatf("result %0d out_x got %h want %h",
                                         results_seen, result.out_x, want.out_x));
                if (result.out_y !== want.out_y)
                    flag_error($sformatf("result %0d out_y got %h want %h",
                                         results_seen, result.out_y, want.out_y));
                if (result.out_z !== want.out_z)
                    flag_error($sformatf("result %0d out_z got %h want %h",
                                         results_seen, result.out_z, want.out_z));
                if (result.overflow !== want.overflow)
                    flag_error($sformatf("result %0d overflow got %b want %b",
                                         results_seen, result.overflow, want.overflow));
            end
            results_seen++;
        end
        // any transfer on any channel counts as progress
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        // sender idle percentage per random phase: none, heavy, light
        int    phase_idle [8] = '{0, 54, 17, 0, 54, 17, 0, 54};
        quat_t ident;
        quat_t q;
        ident = mk_quat(16'sd0, 16'sd0, 16'sd0, QUAT_ONE);

        // after reset: identity, so the result is simply in + offset, clamped
        add_row(0, ident, 0, mk_in(ONE, -ONE, 0, 0, 0, 0), 1, mk_out(ONE, -ONE, 0, 0));
        add_row(0, ident, 0, mk_in(FIX_MAX, FIX_MIN, 0, 0, 0, 0), 1,
                mk_out(FIX_MAX, FIX_MIN, 0, 0));
        add_row(0, ident, 0, mk_in(FIX_MAX, FIX_MIN, 5, 1, -1, 0), 1,
                mk_out(FIX_MAX, FIX_MIN, 5, 1));
        add_row(0, ident, 0, mk_in(FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, -1), 1,
                mk_out(-1, -1, FIX_MIN, 1));
        add_row(0, ident, 0, mk_in(0, 0, 0, FIX_MAX, FIX_MIN, 32'sh1234_5678), 1,
                mk_out(FIX_MAX, FIX_MIN, 32'sh1234_5678, 0));
        // zero quaternion: rotation vanishes, result is the offset; stray index ignored
        add_row(1, mk_quat(0, 0, 0, 0), 1, mk_in(FIX_MAX, FIX_MIN, 123, 7, -7, 0), 1,
                mk_out(7, -7, 0, 0));
        add_row(0, ident, 0, mk_in(ONE, ONE, ONE, FIX_MIN, FIX_MAX, 0), 1,
                mk_out(FIX_MIN, FIX_MAX, 0, 0));
        // most negative quaternion components, heavy scaling
        add_row(1, mk_quat(QMIN, QMIN, QMIN, QMIN), 0,
                mk_in(FIX_MAX, FIX_MAX, FIX_MAX, 0, 0, 0), 0, '0);
        add_row(0, ident, 0, mk_in(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MIN, 0), 0, '0);
        add_row(0, ident, 0, mk_in(ONE, 2 * ONE, -3 * ONE, 0, 0, 0), 0, '0);
        // most positive quaternion components
        add_row(1, mk_quat(QMAX, QMAX, QMAX, QMAX), 0,
                mk_in(FIX_MAX, FIX_MIN, ONE, 0, 0, 0), 0, '0);
        add_row(0, ident, 0, mk_in(ONE, 0, 0, 0, 0, 0), 0, '0);
        // about 90 degrees around z
        add_row(1, mk_quat(0, 0, 16'sd11585, 16'sd11585), 0,
                mk_in(ONE, 0, 0, 0, 0, 0), 0, '0);
        add_row(0, ident, 0, mk_in(0, ONE, 0, 2 * ONE, 0, -ONE), 0, '0);
        // non-unit quaternion, result scaled by |q|^2
        add_row(1, mk_quat(16'sd8192, -16'sd8192, 16'sd16384, -16'sd16384), 1,
                mk_in(32'sh0003_8000, -32'sh0001_2345, 32'sh7000_0000, 0, 0, 0), 0, '0);
        add_row(0, ident, 0, mk_in(-ONE, ONE, -ONE, FIX_MAX, FIX_MIN, 1), 0, '0);
        // smallest scale: exact half steps exercise round-half-up
        add_row(1, mk_quat(0, 0, 0, 16'sd1), 0,
                mk_in(32'sh0800_0000, -32'sh0800_0000, 32'sh07FF_FFFF, 0, 0, 0), 0, '0);
        add_row(0, ident, 0,
                mk_in(32'sh1800_0000, -32'sh1800_0000, FIX_MAX, 0, 0, FIX_MIN), 0, '0);
        // 180 degrees around x, zero scalar part
        add_row(1, mk_quat(16'sd16384, 0, 0, 0), 0, mk_in(ONE, 2 * ONE, 3 * ONE, 0, 0, 0),
                0, '0);
        add_row(0, ident, 0, mk_in(FIX_MIN, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX),
                0, '0);

        // single reset at the start of the run
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, back to back
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].load_quat)
                set_quat(directed_rows[i].quat, directed_rows[i].stray_write);
            send_vector(directed_rows[i].vec, 0, directed_rows[i].typed,
                        directed_rows[i].want);
        end

        // random phases, each with its own quaternion and idle pattern
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: q = ident;
                1: q = mk_quat(QMIN, QMIN, QMIN, QMIN);
                2: q = mk_quat(QMAX, QMAX, QMAX, QMAX);
                default: q = mk_quat(rand_quat_elem(), rand_quat_elem(), rand_quat_elem(),
                                     rand_quat_elem());
            endcase
            set_quat(q, p[0]);
            for (int n = 0; n < 130; n++)
            begin
                // let the pipeline run dry once in the middle of a stream
                if (p == 3 && n == 65)
                begin
                    start <= 1'b0;
                    wait_for_results();
                end
                send_vector(mk_in(rand_fix(), rand_fix(), rand_fix(),
                                  rand_offset(), rand_offset(), rand_offset()),
                            phase_idle[p], 1'b0, '0);
            end
        end

        start <= 1'b0;
        wait_for_results();
        repeat (LATENCY + 2)
            @(posedge clk);
        if (expected_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_q.size()));

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
